[rtl/srctl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctl_pkg
// Shared types and codes for the section relay controller.
// ----------------------------------------------------------------------------
package srctl_pkg;

  // default build sizes
  localparam int NUM_OUTPUTS_DEF  = 8;
  localparam int NUM_SECTIONS_DEF = 16;

  // pin map geometry
  localparam int MAP_PINS = 8;
  localparam int CODE_W   = 5;
  localparam int MAP_W    = MAP_PINS * CODE_W;

  // request kinds carried in tuser
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // lift request codes
  localparam logic [7:0] REQ_LOWER = 8'd1;
  localparam logic [7:0] REQ_RAISE = 8'd2;

  // reported lift state
  localparam logic [1:0] LIFT_IDLE     = 2'd0;
  localparam logic [1:0] LIFT_LOWERING = 2'd1;
  localparam logic [1:0] LIFT_RAISING  = 2'd2;

  // reported mode
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_RAISE_TIME  = 2'd0;
  localparam logic [1:0] REG_LOWER_TIME  = 2'd1;
  localparam logic [1:0] REG_ACTIVE_HIGH = 2'd2;
  localparam logic [1:0] REG_PIN_MAP     = 2'd3;

  // pin function codes
  localparam logic [4:0] FN_SEC_FIRST = 5'd1;
  localparam logic [4:0] FN_SEC_LAST  = 5'd16;
  localparam logic [4:0] FN_LOWER     = 5'd17;
  localparam logic [4:0] FN_RAISE     = 5'd18;
  localparam logic [4:0] FN_TRAM_R    = 5'd19;
  localparam logic [4:0] FN_TRAM_L    = 5'd20;

  // countdown width: 255 * 5 fits in 11 bits
  localparam int CNT_W = 11;

  // lift status handed from the countdown unit to the top
  typedef struct packed {
    logic raise_on;
    logic lower_on;
  } lift_status_t;

endpackage

[rtl/srctl_lift.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctl_lift
// One-shot raise and lower countdowns, advanced once per control tick.
// ----------------------------------------------------------------------------
module srctl_lift import srctl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         tick_fire,
  input  logic [7:0]   lift_req,
  input  logic [7:0]   raise_time,
  input  logic [7:0]   lower_time,
  output lift_status_t status
);

  logic [CNT_W-1:0] raise_cnt_r, raise_cnt_nxt;
  logic [CNT_W-1:0] lower_cnt_r, lower_cnt_nxt;
  logic [1:0]       trig_r, trig_nxt;
  logic             req;
  logic [CNT_W-1:0] raise_x5, lower_x5;

  // pulse lengths in ticks
  assign raise_x5 = CNT_W'({raise_time, 2'b00}) + CNT_W'(raise_time);
  assign lower_x5 = CNT_W'({lower_time, 2'b00}) + CNT_W'(lower_time);

  // countdown step for one tick
  always_comb begin
    req           = (lift_req == REQ_LOWER) || (lift_req == REQ_RAISE);
    raise_cnt_nxt = raise_cnt_r;
    lower_cnt_nxt = lower_cnt_r;
    trig_nxt      = trig_r;
    if (req && (lift_req != {6'd0, trig_r})) begin
      trig_nxt = lift_req[1:0];
      if (lift_req == REQ_LOWER) begin
        raise_cnt_nxt = '0;
        lower_cnt_nxt = lower_x5;
      end else begin
        raise_cnt_nxt = raise_x5;
        lower_cnt_nxt = '0;
      end
    end
    if (raise_cnt_nxt != '0) begin
      raise_cnt_nxt = raise_cnt_nxt - CNT_W'(1);
      lower_cnt_nxt = '0;
    end
    if (lower_cnt_nxt != '0) begin
      lower_cnt_nxt = lower_cnt_nxt - CNT_W'(1);
    end
    if (!req) begin
      raise_cnt_nxt = '0;
      lower_cnt_nxt = '0;
      trig_nxt      = '0;
    end
  end

  // state after this tick, used for the result of the same tick
  assign status.raise_on = (raise_cnt_nxt != '0);
  assign status.lower_on = (lower_cnt_nxt != '0);

  // counters advance on ticks only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raise_cnt_r <= '0;
      lower_cnt_r <= '0;
      trig_r      <= '0;
    end else if (tick_fire) begin
      raise_cnt_r <= raise_cnt_nxt;
      lower_cnt_r <= lower_cnt_nxt;
      trig_r      <= trig_nxt;
    end
  end

endmodule

[rtl/srctl_pin_router.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctl_pin_router
// Routes sections, lift and tram functions to the pins with relay polarity.
// ----------------------------------------------------------------------------
module srctl_pin_router import srctl_pkg::*; #(
  parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
  input  logic [MAP_W-1:0] pin_map,
  input  logic             active_high,
  input  logic [15:0]      sections,
  input  lift_status_t     lift,
  input  logic [1:0]       tram,
  output logic [7:0]       pin_levels
);

  localparam int PINS = (NUM_OUTPUTS < MAP_PINS) ? NUM_OUTPUTS : MAP_PINS;

  logic [CODE_W-1:0] code  [MAP_PINS];
  logic              active[MAP_PINS];

  // decode each pin's function independently
  always_comb begin
    for (int i = 0; i < MAP_PINS; i++) begin
      code[i] = pin_map[CODE_W*i +: CODE_W];
      case (code[i]) inside
        [FN_SEC_FIRST:FN_SEC_LAST]: active[i] = sections[4'(code[i] - 5'd1)];
        FN_LOWER:                   active[i] = lift.lower_on;
        FN_RAISE:                   active[i] = lift.raise_on;
        FN_TRAM_R:                  active[i] = tram[0];
        FN_TRAM_L:                  active[i] = tram[1];
        default:                    active[i] = 1'b0;
      endcase
      // unbuilt pins stay at zero
      if (i < PINS) begin
        pin_levels[i] = ~(active[i] ^ active_high);
      end else begin
        pin_levels[i] = 1'b0;
      end
    end
  end

endmodule

[rtl/section_relay_controller.sv]
`timescale 1ns / 1ps
// Path: an accepted tick request goes from the input register to the result
// register; a command request gives no result.
// Throughput: one request per cycle, except that a tick waits while the result
// register is full and out_tready is low; the state update lies between the two registers.
// Reset: synchronous active-low rst_n clears the valid, state and configuration registers; auto mode set.
// ----------------------------------------------------------------------------
// section_relay_controller
// Section, lift and tram relay controller driven by commands and ticks.
// ----------------------------------------------------------------------------
module section_relay_controller import srctl_pkg::*; #(
  parameter int NUM_OUTPUTS  = NUM_OUTPUTS_DEF,
  parameter int NUM_SECTIONS = NUM_SECTIONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  // tdata: lift_request[7:0], tram_bits[15:8], section_cmd_lo[23:16],
  //        section_cmd_hi[31:24], mode_switch[32], manual_switches[48:33]
  input  logic [55:0]      in_tdata,
  // tuser: action[0]
  input  logic             in_tuser,
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  // tdata: pin_levels[7:0], sections_lo[15:8], sections_hi[23:16],
  //        tram_state[31:24], lift_state[33:32], mode_code[35:34],
  //        manual_on_lo[43:36], manual_off_lo[51:44],
  //        manual_on_hi[59:52], manual_off_hi[67:60]
  output logic [71:0]      out_tdata,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [MAP_W-1:0] cfg_data
);

  localparam int          IN_USED_W = 49;
  localparam logic [15:0] SEC_MASK  = 16'((32'd1 << NUM_SECTIONS) - 32'd1);

  // configuration registers
  logic [7:0]       raise_time_r, lower_time_r;
  logic             active_high_r;
  logic [MAP_W-1:0] pin_map_r;

  // input register
  logic                 in_valid_r;
  logic [IN_USED_W-1:0] in_data_r;
  logic                 in_user_r;

  // block state
  logic        auto_r, auto_nxt;
  logic [15:0] sec_r, sec_nxt;
  logic [7:0]  tram_r, tram_nxt;
  logic [7:0]  lift_r, lift_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r, out_data_nxt;

  logic         proc_ok, tick_fire;
  logic [15:0]  on_bits, off_bits;
  logic [7:0]   pin_levels;
  lift_status_t lift_st;
  logic [1:0]   lift_code;

  // fields of the held request
  logic [7:0]  f_lift, f_tram, f_sec_lo, f_sec_hi;
  logic        f_mode;
  logic [15:0] f_switches;

  assign f_lift     = in_data_r[7:0];
  assign f_tram     = in_data_r[15:8];
  assign f_sec_lo   = in_data_r[23:16];
  assign f_sec_hi   = in_data_r[31:24];
  assign f_mode     = in_data_r[32];
  assign f_switches = in_data_r[48:33];

  // handshake: commands never wait, ticks wait for a free result slot
  assign proc_ok   = in_valid_r && ((in_user_r == ACT_COMMAND) || !out_valid_r || out_tready);
  assign tick_fire = proc_ok && (in_user_r == ACT_TICK);
  assign in_tready = !in_valid_r || proc_ok;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[IN_USED_W-1:0];
      in_user_r <= in_tuser;
    end
  end

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raise_time_r  <= '0;
      lower_time_r  <= '0;
      active_high_r <= 1'b0;
      pin_map_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAISE_TIME:  raise_time_r  <= cfg_data[7:0];
        REG_LOWER_TIME:  lower_time_r  <= cfg_data[7:0];
        REG_ACTIVE_HIGH: active_high_r <= cfg_data[0];
        REG_PIN_MAP:     pin_map_r     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // command and mode handling
  always_comb begin
    auto_nxt = auto_r;
    sec_nxt  = sec_r;
    tram_nxt = tram_r;
    lift_nxt = lift_r;
    on_bits  = '0;
    off_bits = '0;
    if (in_user_r == ACT_COMMAND) begin
      lift_nxt = f_lift;
      tram_nxt = f_tram;
      if (auto_r) begin
        sec_nxt = {f_sec_hi, f_sec_lo} & SEC_MASK;
      end
    end else begin
      auto_nxt = f_mode;
      // manual mode rebuilds sections from the switches
      if (!f_mode) begin
        on_bits  = f_switches & SEC_MASK;
        off_bits = ~on_bits & SEC_MASK;
        sec_nxt  = on_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r <= 1'b1;
      sec_r  <= '0;
      tram_r <= '0;
      lift_r <= '0;
    end else if (proc_ok) begin
      auto_r <= auto_nxt;
      sec_r  <= sec_nxt;
      tram_r <= tram_nxt;
      lift_r <= lift_nxt;
    end
  end

  // lift countdowns
  srctl_lift u_lift (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_fire  (tick_fire),
    .lift_req   (lift_r),
    .raise_time (raise_time_r),
    .lower_time (lower_time_r),
    .status     (lift_st)
  );

  // pin routing
  srctl_pin_router #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_router (
    .pin_map     (pin_map_r),
    .active_high (active_high_r),
    .sections    (sec_nxt),
    .lift        (lift_st),
    .tram        (tram_r[1:0]),
    .pin_levels  (pin_levels)
  );

  // status word
  always_comb begin
    if (lift_st.raise_on) begin
      lift_code = LIFT_RAISING;
    end else if (lift_st.lower_on) begin
      lift_code = LIFT_LOWERING;
    end else begin
      lift_code = LIFT_IDLE;
    end
    out_data_nxt = {4'd0, off_bits[15:8], on_bits[15:8], off_bits[7:0], on_bits[7:0],
                    (auto_nxt ? MODE_AUTO : MODE_MANUAL), lift_code, tram_r,
                    sec_nxt[15:8], sec_nxt[7:0], pin_levels};
  end

  // result register
  always_comb begin
    if (tick_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // lift state never reports raising and lowering together
  a_lift_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] != 2'd3))
    else $error("lift state code out of range");

  // manual report: on and off sets are disjoint
  a_manual_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[35:34] == MODE_MANUAL)) |->
      (((out_tdata[43:36] & out_tdata[51:44]) == 8'd0) &&
       ((out_tdata[59:52] & out_tdata[67:60]) == 8'd0)))
    else $error("manual on and off overlap");

  // auto report carries no manual bytes
  a_auto_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[35:34] == MODE_AUTO)) |-> (out_tdata[67:36] == 32'd0))
    else $error("manual bytes set in auto mode");

  // a held request is kept until it is processed
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proc_ok) |=> (in_valid_r && $stable(in_data_r) && $stable(in_user_r)))
    else $error("held request lost");

endmodule
